/* design/mrt_pkg.sv */
package mrt_pkg;

   // table size and derived widths
   localparam int TABLE_DEPTH = 16;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // operation codes
   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_MODIFY = 2'd2;
   localparam logic [1:0] KIND_LOOKUP = 2'd3;

   // result status codes
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] dest_addr;
      logic [31:0] route_mask;
      logic [31:0] hop_addr;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] next_hop;
      logic [1:0]  status;
   } rsp_type;

   // one stored route
   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
      logic [31:0] hop;
   } entry_type;

   // transaction token walking down the cell chain
   typedef struct packed {
      logic        valid;
      logic        found;
      logic [31:0] res_hop;
      req_type     req;
   } token_type;

endpackage

/* design/mrt_cell.sv */
module mrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               entry_valid,
   input  mrt_pkg::token_type tok_in,
   output mrt_pkg::token_type tok_out,
   input  mrt_pkg::entry_type next_entry,
   output mrt_pkg::entry_type entry_out
);
   import mrt_pkg::*;

   token_type tok_ff, tok_stage_in;
   entry_type entry_ff, entry_in;
   logic      exact_eq;
   logic      masked_eq;

   // compares against the stored route
   assign exact_eq  = entry_valid && (entry_ff.dest == tok_in.req.dest_addr)
                      && (entry_ff.mask == tok_in.req.route_mask);
   assign masked_eq = entry_valid
                      && (((entry_ff.dest ^ tok_in.req.dest_addr) & entry_ff.mask) == 32'd0);

   // per-cell operation on the passing transaction
   always_comb begin
      tok_stage_in = tok_in;
      entry_in     = entry_ff;
      if (tok_in.valid && !tok_in.found) begin
         case (tok_in.req.kind)
            KIND_ADD: begin
               // first free cell takes the new route
               if (!entry_valid) begin
                  entry_in.dest      = tok_in.req.dest_addr;
                  entry_in.mask      = tok_in.req.route_mask;
                  entry_in.hop       = tok_in.req.hop_addr;
                  tok_stage_in.found = 1'b1;
               end
            end
            KIND_DELETE: begin
               if (exact_eq) begin
                  tok_stage_in.found = 1'b1;
               end
            end
            KIND_MODIFY: begin
               if (exact_eq) begin
                  entry_in.hop       = tok_in.req.hop_addr;
                  tok_stage_in.found = 1'b1;
               end
            end
            default: begin
               if (masked_eq) begin
                  tok_stage_in.found   = 1'b1;
                  tok_stage_in.res_hop = entry_ff.hop;
               end
            end
         endcase
      end
      // a delete that has passed here pulls the next route up one place
      if (tok_ff.valid && tok_ff.found && (tok_ff.req.kind == KIND_DELETE)) begin
         entry_in = next_entry;
      end
   end

   // token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_stage_in;
      end
   end

   // route storage
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign tok_out   = tok_ff;
   assign entry_out = entry_ff;

endmodule

/* design/masked_route_table.sv */
// Channel  | Direction | Ports                                  | Payload
// request  | in        | req_valid, req_ready, req_data         | kind, dest, mask, hop
// response | out       | rsp_valid, rsp_ready, rsp_data         | hit, next_hop, status
//
// A transaction walks the chain of TABLE_DEPTH route cells, one cell per cycle, then
// passes a result stage into the output register. Only one transaction is in the table
// at a time: no new request is taken until the result has left the result stage.
// A new request is taken once the previous result sits in the output register,
// even while that result is still stalled.
// Reset empties the table (route count to zero); no clearing pass is needed.
module masked_route_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mrt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mrt_pkg::rsp_type rsp_data
);
   import mrt_pkg::*;

   token_type           tok [0:TABLE_DEPTH];
   entry_type           ent [0:TABLE_DEPTH-1];
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                tail_valid_ff, tail_valid_in;
   rsp_type             tail_ff, tail_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                accept;
   logic                tail_move;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign tail_move = tail_valid_ff && (!rsp_valid_ff || rsp_ready);

   // head of the chain
   always_comb begin
      tok[0].valid   = accept;
      tok[0].found   = 1'b0;
      tok[0].res_hop = 32'd0;
      tok[0].req     = req_data;
   end

   // row of route cells
   genvar i;
   generate
      for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
         entry_type nxt;
         if (i == TABLE_DEPTH - 1) begin : g_last
            assign nxt = '0;
         end else begin : g_mid
            assign nxt = ent[i+1];
         end
         mrt_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .entry_valid (count_ff > CNT_W'(i)),
            .tok_in      (tok[i]),
            .tok_out     (tok[i+1]),
            .next_entry  (nxt),
            .entry_out   (ent[i])
         );
      end
   endgenerate

   // result forming, route count and output staging
   always_comb begin
      count_in      = count_ff;
      busy_in       = busy_ff;
      tail_valid_in = tail_valid_ff;
      tail_in       = tail_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (accept) begin
         busy_in = 1'b1;
      end

      if (tok[TABLE_DEPTH].valid) begin
         tail_valid_in    = 1'b1;
         tail_in.hit      = 1'b0;
         tail_in.next_hop = 32'd0;
         tail_in.status   = ST_DONE;
         case (tok[TABLE_DEPTH].req.kind)
            KIND_ADD: begin
               if (tok[TABLE_DEPTH].found) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  tail_in.status = ST_FULL;
               end
            end
            KIND_DELETE: begin
               if (tok[TABLE_DEPTH].found) begin
                  count_in    = count_ff - CNT_W'(1);
                  tail_in.hit = 1'b1;
               end else begin
                  tail_in.status = ST_NONE;
               end
            end
            KIND_MODIFY: begin
               if (tok[TABLE_DEPTH].found) begin
                  tail_in.hit = 1'b1;
               end else begin
                  tail_in.status = ST_NONE;
               end
            end
            default: begin
               if (tok[TABLE_DEPTH].found) begin
                  tail_in.hit      = 1'b1;
                  tail_in.next_hop = tok[TABLE_DEPTH].res_hop;
               end else begin
                  tail_in.status = ST_NONE;
               end
            end
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (tail_move) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = tail_ff;
         tail_valid_in = 1'b0;
         busy_in       = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         tail_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         tail_valid_ff <= tail_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* design/mrt_checker.sv */
module mrt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input mrt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mrt_pkg::rsp_type rsp_data
);
   import mrt_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one transaction in the chain at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in flight");

   // a hit always completes
   a_hit_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.status == ST_DONE)
      else $error("hit with failing status");

   // a failure carries no hit and no next hop
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_DONE) |->
         !rsp_data.hit && (rsp_data.next_hop == 32'd0))
      else $error("failing transaction carries a hit or next hop");

   // request kind kept visible to the checker for the stability check
   logic [1:0] req_kind_seen;
   assign req_kind_seen = req_data.kind;

   a_kind_stable: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> $stable(req_kind_seen) || !req_valid)
      else $error("request kind changed while waiting");

endmodule

bind masked_route_table mrt_checker u_mrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* bench/masked_route_table_tb.sv */
`timescale 1ns / 100ps

import mrt_pkg::*;

// Shadow route table: predicts each response as its request is accepted
class route_scoreboard;
   entry_type   routes [TABLE_DEPTH];
   int unsigned route_count = 0;
   rsp_type     pending_results [$];
   int unsigned error_count = 0;

   // first entry whose destination and mask both equal the given pair, or -1
   function int find_route(logic [31:0] dest, logic [31:0] mask);
      for (int i = 0; i < route_count; i++) begin
         if (routes[i].dest == dest && routes[i].mask == mask) return i;
      end
      return -1;
   endfunction

   // apply an accepted request to the shadow table, queue its response
   function void record_request(req_type item);
      rsp_type res;
      int      idx;
      res        = '0;
      res.status = ST_DONE;
      case (item.kind)
         KIND_ADD: begin
            if (route_count >= TABLE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               routes[route_count].dest = item.dest_addr;
               routes[route_count].mask = item.route_mask;
               routes[route_count].hop  = item.hop_addr;
               route_count++;
            end
         end
         KIND_DELETE: begin
            idx = find_route(item.dest_addr, item.route_mask);
            if (idx < 0) begin
               res.status = ST_NONE;
            end else begin
               // later routes close the gap, order kept
               for (int i = idx; i + 1 < route_count; i++) routes[i] = routes[i + 1];
               route_count--;
               res.hit = 1'b1;
            end
         end
         KIND_MODIFY: begin
            idx = find_route(item.dest_addr, item.route_mask);
            if (idx < 0) begin
               res.status = ST_NONE;
            end else begin
               routes[idx].hop = item.hop_addr;
               res.hit         = 1'b1;
            end
         end
         default: begin
            // first match in table order, not longest prefix
            res.status = ST_NONE;
            for (int i = 0; i < route_count; i++) begin
               if ((routes[i].dest & routes[i].mask) == (item.dest_addr & routes[i].mask)) begin
                  res.hit      = 1'b1;
                  res.next_hop = routes[i].hop;
                  res.status   = ST_DONE;
                  break;
               end
            end
         end
      endcase
      pending_results = {pending_results, res};
   endfunction

   // compare one response with the oldest prediction
   function void check_response(rsp_type actual);
      rsp_type want;
      if (pending_results.size() == 0) begin
         error_count++;
         $display("%0t: response with no transaction outstanding: expected none, actual %h",
                  $time, actual);
         return;
      end
      want = pending_results.pop_front();
      if (actual.hit !== want.hit) begin
         error_count++;
         $display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit, actual.hit);
      end
      if (actual.next_hop !== want.next_hop) begin
         error_count++;
         $display("%0t: next_hop mismatch: expected %h, actual %h",
                  $time, want.next_hop, actual.next_hop);
      end
      if (actual.status !== want.status) begin
         error_count++;
         $display("%0t: status mismatch: expected %0d, actual %0d",
                  $time, want.status, actual.status);
      end
   endfunction

   function int unsigned outstanding();
      return pending_results.size();
   endfunction
endclass

module masked_route_table_tb;

   localparam int unsigned RANDOM_ITEMS = 1850;
   localparam int unsigned QUIET_ITEMS  = 250;
   localparam int unsigned CYCLE_LIMIT  = 500000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   route_scoreboard route_sb = new;
   bit              quiet_tail;
   bit              grow_table;
   int unsigned     cycle_count;

   masked_route_table DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // hold a transaction until accepted, then update the prediction
   task automatic issue_request(input req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      route_sb.record_request(item);
   endtask

   task automatic issue_op(input logic [1:0] kind, input logic [31:0] dest,
                           input logic [31:0] mask, input logic [31:0] hop);
      req_type item;
      item.kind       = kind;
      item.dest_addr  = dest;
      item.route_mask = mask;
      item.hop_addr   = hop;
      issue_request(item);
   endtask

   task automatic sender_gap(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop sending until every outstanding response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (route_sb.outstanding() != 0) @(posedge clock);
   endtask

   // mostly prefix masks, sometimes arbitrary bit patterns
   function automatic logic [31:0] random_mask();
      int unsigned plen;
      plen = $urandom_range(0, 32);
      if ($urandom_range(0, 9) < 7) return 32'hFFFF_FFFF << (32 - plen);
      return $urandom;
   endfunction

   // random transaction, steered towards routes in the shadow table
   function automatic req_type random_request();
      req_type     item;
      entry_type   known;
      int unsigned roll;
      int unsigned add_share;
      item.kind       = KIND_LOOKUP;
      item.dest_addr  = $urandom;
      item.route_mask = $urandom;
      item.hop_addr   = $urandom;
      known           = '0;
      if (route_sb.route_count != 0)
         known = route_sb.routes[$urandom_range(0, route_sb.route_count - 1)];
      add_share = grow_table ? 50 : 10;
      roll      = $urandom_range(0, 99);
      if (roll < add_share) begin
         item.kind = KIND_ADD;
         if (route_sb.route_count != 0 && $urandom_range(0, 9) == 0) begin
            // duplicate route
            item.dest_addr  = known.dest;
            item.route_mask = known.mask;
         end else begin
            item.route_mask = random_mask();
         end
      end else if (roll < add_share + (100 - add_share) / 2) begin
         item.kind       = ($urandom_range(0, 2) == 0) ? KIND_MODIFY : KIND_DELETE;
         item.route_mask = random_mask();
         if (route_sb.route_count != 0 && $urandom_range(0, 3) != 0) begin
            item.dest_addr  = known.dest;
            item.route_mask = known.mask;
         end else if (route_sb.route_count != 0 && $urandom_range(0, 1) == 1) begin
            // near miss: one bit off in destination or mask
            item.dest_addr  = known.dest;
            item.route_mask = known.mask;
            if ($urandom_range(0, 1) == 1)
               item.dest_addr = known.dest ^ (32'd1 << $urandom_range(0, 31));
            else
               item.route_mask = known.mask ^ (32'd1 << $urandom_range(0, 31));
         end
      end else begin
         // lookup inside a known route with random host bits
         if (route_sb.route_count != 0 && $urandom_range(0, 9) < 7)
            item.dest_addr = (known.dest & known.mask) | ($urandom & ~known.mask);
      end
      return item;
   endfunction

   // response side: random bursts of ready and stall, none in the tail
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (quiet_tail || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
         end
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) route_sb.check_response(rsp_data);
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** masked_route_table: FAILED **");
      $finish;
   end

   // stimulus
   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      quiet_tail = 1'b0;
      grow_table = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: lookup and delete both miss
      issue_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue_op(KIND_DELETE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      // fill: subnet, host, duplicate subnet, default route, then host routes
      issue_op(KIND_ADD, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hFFFF_FFFF);
      issue_op(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0A00_0001);
      issue_op(KIND_ADD, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0A00_0002);
      issue_op(KIND_ADD, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678);
      for (int k = 4; k < TABLE_DEPTH; k++)
         issue_op(KIND_ADD, $urandom, 32'hFFFF_FFFF, $urandom);
      // table full
      issue_op(KIND_ADD, 32'h0102_0304, 32'hFFFF_0000, 32'h5555_5555);
      // first of the duplicates wins
      issue_op(KIND_LOOKUP, 32'hC0A8_01FF, 32'h0000_0000, 32'h0000_0000);
      issue_op(KIND_MODIFY, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0000_0000);
      issue_op(KIND_LOOKUP, 32'hC0A8_0155, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // delete shifts the duplicate up
      issue_op(KIND_DELETE, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hFFFF_FFFF);
      issue_op(KIND_LOOKUP, 32'hC0A8_0101, 32'h0000_0000, 32'h0000_0000);
      issue_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      // default route catches the rest
      issue_op(KIND_LOOKUP, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000);
      // equal destination but other mask: no entry
      issue_op(KIND_MODIFY, 32'hC0A8_0100, 32'hFFFF_0000, 32'hAAAA_AAAA);
      drain_responses();

      // random traffic, table alternately growing and shrinking
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
         if ($urandom_range(0, 39) == 0) grow_table = ~grow_table;
         if (n % 600 == 300) begin
            drain_responses();
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            sender_gap($urandom_range(1, 12));
         end
         issue_request(random_request());
      end

      drain_responses();
      repeat (TABLE_DEPTH + 4) @(posedge clock);
      if (route_sb.error_count == 0 && route_sb.outstanding() == 0) begin
         $display("** masked_route_table: PASSED **");
      end else begin
         $display("** masked_route_table: FAILED **");
      end
      $finish;
   end

endmodule
